/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// next-cycle implication, checked on every rising edge outside reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

/* sv/fhss_pkg.sv */
`timescale 1ns / 1ps

package fhss_pkg;

  localparam int PATTERN_BYTES = 16;
  localparam int CNT_W         = 16;
  localparam int HOST_LEN_W    = 5;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 64;

  // fixed host text that the window looks for, first byte first
  localparam logic [7:0] PATTERN [PATTERN_BYTES] = '{
    8'h6e, 8'h69, 8'h6e, 8'h74, 8'h65, 8'h6e, 8'h64, 8'h6f,
    8'h77, 8'h69, 8'h66, 8'h69, 8'h2e, 8'h6e, 8'h65, 8'h74
  };

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOST_LOW  = 2'd0,
    CFG_HOST_HIGH = 2'd1,
    CFG_HOST_LEN  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             out_last;
    logic [CNT_W-1:0] replacements;
  } out_item_t;

endpackage

/* sv/fixed_host_substitution_stream_top.sv */
`timescale 1ns / 1ps

// channel  | direction | handshake              | beat
// ---------+-----------+------------------------+----------------------------------
// in       | input     | in_valid / in_stall    | in_item_t: in_byte, in_last
// out      | output    | out_valid / out_stall  | out_item_t: out_byte, out_last, replacements
// cfg      | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data (64 bit)
//
// one input register feeds a single pass of window compare and edit logic that
// loads a result shift register of 16 bytes; output drains one beat per cycle while
// out_stall is low, and the sustained rate is then one beat per cycle; an input byte that yields
// k output beats (a match, a string end or a buffer end) stalls the input while the result
// shift register drains; a byte with one or no result delays the next only on out_stall.
// rst is synchronous, active high, and clears control state, counters and
// the configuration registers. output stall holds the result register; the
// input register keeps taking one more byte while an output beat waits.
module fixed_host_substitution_stream_top
  import fhss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "assert_macros.svh"

  // configuration registers
  logic [63:0]           host_low;
  logic [63:0]           host_high;
  logic [HOST_LEN_W-1:0] host_length;

  // input register
  logic     pend_valid;
  in_item_t pend;

  // scan state
  logic [7:0]       win [PATTERN_BYTES-1];
  logic [3:0]       fill;
  logic             in_str;
  logic [3:0]       debt;
  logic [CNT_W-1:0] count;

  // result shift register
  logic [7:0]       burst [PATTERN_BYTES];
  logic [4:0]       bcnt;
  logic             blast;
  logic [CNT_W-1:0] brep;

  // step logic outputs
  logic [7:0]       wnew [PATTERN_BYTES];
  logic [7:0]       res [PATTERN_BYTES];
  logic [4:0]       n;
  logic [7:0]       win_next [PATTERN_BYTES-1];
  logic [3:0]       fill_next;
  logic             in_str_next;
  logic [3:0]       debt_next;
  logic [CNT_W-1:0] count_next;
  logic             match;
  logic             pat_eq;
  logic             hlen_ok;
  logic [4:0]       newfill;
  logic [4:0]       nz;
  logic [7:0]       b;
  logic             last;

  logic in_acc;
  logic out_acc;
  logic burst_free;
  logic step;

  // handshakes
  assign cfg_ready  = 1'b1;
  assign out_valid  = (bcnt != 5'd0);
  assign out_acc    = out_valid && !out_stall;
  assign burst_free = (bcnt == 5'd0) || ((bcnt == 5'd1) && out_acc);
  assign step       = pend_valid && burst_free;
  assign in_stall   = pend_valid && !step;
  assign in_acc     = in_valid && !in_stall;

  assign out_data.out_byte     = burst[0];
  assign out_data.out_last     = blast && (bcnt == 5'd1);
  assign out_data.replacements = brep;

  assign b    = pend.in_byte;
  assign last = pend.in_last;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      host_low    <= '0;
      host_high   <= '0;
      host_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HOST_LOW:  host_low    <= cfg_data;
        CFG_HOST_HIGH: host_high   <= cfg_data;
        CFG_HOST_LEN:  host_length <= cfg_data[HOST_LEN_W-1:0];
        default:       ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_acc) begin
      pend_valid <= 1'b1;
    end else if (step) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pend <= in_data;
    end
  end

  // window with the new byte written at the fill position
  always_comb begin
    for (int i = 0; i < PATTERN_BYTES - 1; i++) begin
      wnew[i] = (fill == 4'(i)) ? b : win[i];
    end
    wnew[PATTERN_BYTES-1] = b;
    pat_eq = 1'b1;
    for (int i = 0; i < PATTERN_BYTES; i++) begin
      if (wnew[i] != PATTERN[i]) begin
        pat_eq = 1'b0;
      end
    end
  end

  assign newfill = {1'b0, fill} + 5'd1;
  assign hlen_ok = (host_length != '0) && (host_length <= 5'(PATTERN_BYTES));
  assign match   = !in_str && (fill == 4'd15) && hlen_ok && pat_eq;

  // edit logic: result bytes, their count and the next scan state
  always_comb begin
    for (int k = 0; k < PATTERN_BYTES; k++) begin
      res[k] = '0;
    end
    for (int i = 0; i < PATTERN_BYTES - 1; i++) begin
      win_next[i] = wnew[i];
    end
    n           = '0;
    nz          = '0;
    fill_next   = newfill[3:0];
    in_str_next = in_str;
    debt_next   = debt;
    count_next  = count;

    if (in_str) begin
      // rest of a replaced string passes; terminator or buffer end pays the debt
      if (b != 8'd0) begin
        res[0] = b;
      end
      if ((b == 8'd0) || last) begin
        nz          = 5'(debt) + 5'(b == 8'd0);
        in_str_next = 1'b0;
        debt_next   = '0;
      end
      n         = 5'(b != 8'd0) + nz;
      fill_next = fill;
    end else if (match) begin
      // host bytes, then zeros when the buffer ends here
      for (int k = 0; k < PATTERN_BYTES; k++) begin
        if (5'(k) < host_length) begin
          res[k] = (k < 8) ? host_low[8*(k%8) +: 8] : host_high[8*(k%8) +: 8];
        end
      end
      n           = last ? 5'(PATTERN_BYTES) : host_length;
      fill_next   = '0;
      debt_next   = last ? 4'd0 : 4'(5'(PATTERN_BYTES) - host_length);
      in_str_next = !last;
      if (count != {CNT_W{1'b1}}) begin
        count_next = count + CNT_W'(1);
      end
    end else if (last) begin
      // buffer end flushes every held byte
      for (int k = 0; k < PATTERN_BYTES; k++) begin
        res[k] = wnew[k];
      end
      n         = newfill;
      fill_next = '0;
    end else if (fill == 4'd15) begin
      // window full: oldest byte leaves
      res[0] = wnew[0];
      n      = 5'd1;
      for (int i = 0; i < PATTERN_BYTES - 1; i++) begin
        win_next[i] = wnew[i+1];
      end
      fill_next = 4'd15;
    end

    if (last) begin
      fill_next   = '0;
      in_str_next = 1'b0;
      debt_next   = '0;
    end
  end

  // scan state update
  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      in_str <= 1'b0;
      debt   <= '0;
      count  <= '0;
    end else if (step) begin
      fill   <= fill_next;
      in_str <= in_str_next;
      debt   <= debt_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      win <= win_next;
    end
  end

  // result shift register count
  always_ff @(posedge clk) begin
    if (rst) begin
      bcnt <= '0;
    end else if (step) begin
      bcnt <= n;
    end else if (out_acc) begin
      bcnt <= bcnt - 5'd1;
    end
  end

  // result bytes load on a step, shift on each delivered beat
  always_ff @(posedge clk) begin
    if (step) begin
      burst <= res;
      blast <= last;
      brep  <= count_next;
    end else if (out_acc) begin
      for (int i = 0; i < PATTERN_BYTES - 1; i++) begin
        burst[i] <= burst[i+1];
      end
      burst[PATTERN_BYTES-1] <= '0;
    end
  end

  // checks
  `ASSERT_NOW(a_last_fresh, out_valid && out_data.out_last, !in_str && fill == '0 && debt == '0)
  `ASSERT_NEXT(a_count_monotonic, 1'b1, count >= $past(count))
  `ASSERT_NOW(a_string_window_empty, in_str, fill == 4'd0)

endmodule
